@@ rtl/spq_pkg.sv @@
// shared command and status codes and cell control type for the priority queue
package spq_pkg;

   localparam int CMD_BITS    = 2;
   localparam int STATUS_BITS = 2;

   localparam logic [CMD_BITS-1:0] CMD_ENQUEUE = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_DEQUEUE = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_SEARCH  = 2'd2;

   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic enq;
      logic deq;
   } spq_ctrl_type;

endpackage

@@ rtl/spq_if.sv @@
// request and response channel interfaces of the priority queue
interface spq_req_if
   import spq_pkg::*;
#(
   parameter int TAG_BITS     = 16,
   parameter int URGENCY_BITS = 8
);
   logic                    valid;
   logic                    ready;
   logic [CMD_BITS-1:0]     command;
   logic [TAG_BITS-1:0]     item_tag;
   logic [URGENCY_BITS-1:0] item_urgency;

   modport source (output valid, command, item_tag, item_urgency, input ready);
   modport sink   (input valid, command, item_tag, item_urgency, output ready);
endinterface

interface spq_rsp_if
   import spq_pkg::*;
#(
   parameter int TAG_BITS     = 16,
   parameter int URGENCY_BITS = 8,
   parameter int CNT_BITS     = 5
);
   logic                    valid;
   logic                    ready;
   logic [STATUS_BITS-1:0]  status;
   logic [TAG_BITS-1:0]     head_tag;
   logic [URGENCY_BITS-1:0] head_urgency;
   logic                    found;
   logic [CNT_BITS-1:0]     occupancy;

   modport source (output valid, status, head_tag, head_urgency, found, occupancy,
                   input ready);
   modport sink   (input valid, status, head_tag, head_urgency, found, occupancy,
                   output ready);
endinterface

@@ rtl/spq_cell.sv @@
// one slot of the sorted queue, shifting toward its neighbors
module spq_cell
   import spq_pkg::*;
#(
   parameter int TAG_BITS     = 16,
   parameter int URGENCY_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  spq_ctrl_type            ctrl,
   input  logic [TAG_BITS-1:0]     new_tag,
   input  logic [URGENCY_BITS-1:0] new_urg,
   input  logic                    left_used,
   input  logic                    left_keep,
   input  logic [TAG_BITS-1:0]     left_tag,
   input  logic [URGENCY_BITS-1:0] left_urg,
   input  logic                    right_used,
   input  logic [TAG_BITS-1:0]     right_tag,
   input  logic [URGENCY_BITS-1:0] right_urg,
   output logic                    used,
   output logic                    keep,
   output logic                    match,
   output logic [TAG_BITS-1:0]     tag,
   output logic [URGENCY_BITS-1:0] urg
);
   logic                    used_ff, used_in;
   logic [TAG_BITS-1:0]     tag_ff, tag_in;
   logic [URGENCY_BITS-1:0] urg_ff, urg_in;

   assign keep  = used_ff && (urg_ff >= new_urg);
   assign match = used_ff && (tag_ff == new_tag);
   assign used  = used_ff;
   assign tag   = tag_ff;
   assign urg   = urg_ff;

   always_comb begin
      used_in = used_ff;
      tag_in  = tag_ff;
      urg_in  = urg_ff;
      if (ctrl.enq && !keep) begin
         used_in = used_ff | left_used;
         if (left_keep) begin
            tag_in = new_tag;
            urg_in = new_urg;
         end else begin
            tag_in = left_tag;
            urg_in = left_urg;
         end
      end else if (ctrl.deq) begin
         used_in = right_used;
         tag_in  = right_tag;
         urg_in  = right_urg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
      end
      tag_ff <= tag_in;
      urg_ff <= urg_in;
   end

endmodule

@@ rtl/stable_priority_queue.sv @@
// top level: chain of slot cells forming a stable sorted priority queue
// the result item is registered and appears in the cycle after its request item is accepted
// one item per cycle while not stalled; every cell compares and shifts in the same cycle
// the request side stalls only while a result item waits and the response side is not ready
// reset: synchronous, clears all used marks, the fill count and the result valid
module stable_priority_queue
   import spq_pkg::*;
#(
   parameter int DEPTH        = 16,
   parameter int TAG_BITS     = 16,
   parameter int URGENCY_BITS = 8
) (
   input  logic    clock,
   input  logic    reset,
   spq_req_if.sink   req_ch,
   spq_rsp_if.source rsp_ch
);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic                    used_vec  [DEPTH];
   logic                    keep_vec  [DEPTH];
   logic [DEPTH-1:0]        match_vec;
   logic [TAG_BITS-1:0]     tag_arr   [DEPTH];
   logic [URGENCY_BITS-1:0] urg_arr   [DEPTH];
   logic [DEPTH-1:0]        used_bits;

   logic                    accept;
   logic                    full;
   logic                    empty;
   logic                    enq_ok;
   logic                    deq_ok;
   spq_ctrl_type            ctrl;

   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0]  status_ff, status_in;
   logic [TAG_BITS-1:0]     head_tag_ff, head_tag_in;
   logic [URGENCY_BITS-1:0] head_urg_ff, head_urg_in;
   logic                    found_ff, found_in;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign full         = used_vec[DEPTH-1];
   assign empty        = !used_vec[0];
   assign enq_ok       = accept && (req_ch.command == CMD_ENQUEUE) && !full;
   assign deq_ok       = accept && (req_ch.command == CMD_DEQUEUE) && !empty;
   assign ctrl.enq     = enq_ok;
   assign ctrl.deq     = deq_ok;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                    l_used, l_keep, r_used;
      logic [TAG_BITS-1:0]     l_tag, r_tag;
      logic [URGENCY_BITS-1:0] l_urg, r_urg;

      if (i == 0) begin : g_first
         assign l_used = 1'b1;
         assign l_keep = 1'b1;
         assign l_tag  = req_ch.item_tag;
         assign l_urg  = req_ch.item_urgency;
      end else begin : g_mid
         assign l_used = used_vec[i-1];
         assign l_keep = keep_vec[i-1];
         assign l_tag  = tag_arr[i-1];
         assign l_urg  = urg_arr[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign r_used = 1'b0;
         assign r_tag  = tag_arr[i];
         assign r_urg  = urg_arr[i];
      end else begin : g_inner
         assign r_used = used_vec[i+1];
         assign r_tag  = tag_arr[i+1];
         assign r_urg  = urg_arr[i+1];
      end

      spq_cell #(
         .TAG_BITS     (TAG_BITS),
         .URGENCY_BITS (URGENCY_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .new_tag    (req_ch.item_tag),
         .new_urg    (req_ch.item_urgency),
         .left_used  (l_used),
         .left_keep  (l_keep),
         .left_tag   (l_tag),
         .left_urg   (l_urg),
         .right_used (r_used),
         .right_tag  (r_tag),
         .right_urg  (r_urg),
         .used       (used_vec[i]),
         .keep       (keep_vec[i]),
         .match      (match_vec[i]),
         .tag        (tag_arr[i]),
         .urg        (urg_arr[i])
      );

      assign used_bits[i] = used_vec[i];
   end

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      head_tag_in  = head_tag_ff;
      head_urg_in  = head_urg_ff;
      found_in     = found_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         status_in    = STATUS_OK;
         head_tag_in  = '0;
         head_urg_in  = '0;
         found_in     = 1'b0;
         case (req_ch.command)
            CMD_ENQUEUE: begin
               if (full) begin
                  status_in = STATUS_FULL;
               end else begin
                  count_in = count_ff + CNT_BITS'(1);
               end
            end
            CMD_DEQUEUE: begin
               if (empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  head_tag_in = tag_arr[0];
                  head_urg_in = urg_arr[0];
                  count_in    = count_ff - CNT_BITS'(1);
               end
            end
            CMD_SEARCH: begin
               found_in = |match_vec;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff   <= status_in;
      head_tag_ff <= head_tag_in;
      head_urg_ff <= head_urg_in;
      found_ff    <= found_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = status_ff;
   assign rsp_ch.head_tag     = head_tag_ff;
   assign rsp_ch.head_urgency = head_urg_ff;
   assign rsp_ch.found        = found_ff;
   assign rsp_ch.occupancy    = count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("fill count above depth");

   a_used_matches_count: assert property (@(posedge clock) disable iff (reset)
      $countones(used_bits) == 32'(count_ff))
      else $error("used marks disagree with fill count");

   a_enq_grows: assert property (@(posedge clock) disable iff (reset)
      enq_ok |=> count_ff == $past(count_ff) + CNT_BITS'(1))
      else $error("enqueue did not grow the queue");

   a_head_order: assert property (@(posedge clock) disable iff (reset)
      used_vec[1] |-> urg_arr[0] >= urg_arr[1])
      else $error("head slots out of order");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (accept && req_ch.command == CMD_ENQUEUE && full) |=> status_ff == STATUS_FULL)
      else $error("enqueue on full queue not flagged");

endmodule
